### rtl/sorted_key_node_defines.svh
// Assertion macros shared by the sorted key node RTL.
`ifndef SORTED_KEY_NODE_DEFINES_SVH
`define SORTED_KEY_NODE_DEFINES_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define SKN_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define SKN_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/skn_pkg.sv
// Types and constants shared by the sorted key node modules.
`timescale 1ns / 1ps
`default_nettype none
package skn_pkg;

	localparam int CMD_W    = 2;
	localparam int IN_KEY_W = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 5;
	localparam int COUNT_W  = 5;
	localparam int IN_W     = 40;
	localparam int OUT_W    = 16;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_SEARCH = 2'd2
	} skn_cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_NOT_FOUND = 2'd3
	} skn_status_t;

	typedef enum logic {
		FSM_IDLE,
		FSM_UPDATE
	} skn_fsm_t;

	// Control that every cell of the row sees in the same cycle.
	typedef struct packed {
		logic compare;
		logic shift_up;
		logic shift_down;
	} skn_ctl_t;

endpackage
`default_nettype wire

### rtl/sorted_key_node.sv
// Top level of the sorted key node: a row of key cells with a command sequencer.
//
// Keeps up to SIZE keys in ascending order. Each item on the s_ channel carries
// a command (insert, remove, search) and a key; each item yields exactly one
// result on the m_ channel: status, position, found flag and the key count.
// An accepted item is compared against every cell at once in the cycle it is
// accepted, and the cells register the compare flags; in the update state the
// match position and found flag are reduced from the row, the cells shift up
// or down by one place, and the result is loaded into the output register. An
// item thus passes through the compare stage held in the cells and then the
// row update. s_tready is high while no item is in the row, so a new item is
// taken while an earlier result still waits in the output register.
// If the receiver stalls with a result held, the update of the next item waits
// until that result is taken. Reset empties the node (count zero) and clears
// the output valid flag; stored keys need no clearing.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_key_node_defines.svh"
module sorted_key_node #(
	parameter int SIZE      = 16,
	parameter int KEY_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// cmd [1:0], key [33:2], zero fill [39:34]
	input  wire logic [skn_pkg::IN_W-1:0]    s_tdata,
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// status [1:0], position [6:2], found [7], count [12:8], zero fill [15:13]
	output logic      [skn_pkg::OUT_W-1:0]   m_tdata
);
	import skn_pkg::*;

	localparam int CW = $clog2(SIZE + 1);

	skn_fsm_t               state_q, state_nxt;
	skn_ctl_t               ctl;
	logic                   load;
	logic [CW-1:0]          count_q;
	logic [CMD_W-1:0]       cmd_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [KEY_WIDTH-1:0]   in_key;
	logic [63:0]            in_key_ext;
	logic                   accept;
	logic                   not_full;

	logic [KEY_WIDTH-1:0]   cell_key [SIZE];
	logic [SIZE-1:0]        cell_lt;
	logic [SIZE-1:0]        cell_at_pos;
	logic [SIZE-1:0]        cell_hit;
	logic [SIZE-1:0]        cell_valid;

	logic [CW-1:0]          pos_enc;
	logic [CW-1:0]          pos;
	logic                   found;
	logic [STATUS_W-1:0]    status;
	logic [CW-1:0]          pos_out;
	logic                   found_out;
	logic [CW+POS_W-1:0]    pos_pad;
	logic [CW+COUNT_W-1:0]  count_pad;
	logic [CW-1:0]          count_nxt;

	logic                   m_tvalid_q;
	logic [OUT_W-1:0]       m_tdata_q;

	assign accept     = s_tvalid && s_tready;
	assign in_key_ext = {32'd0, s_tdata[CMD_W +: IN_KEY_W]};
	assign in_key     = in_key_ext[KEY_WIDTH-1:0];
	assign not_full   = (count_q < CW'(SIZE));

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt      = state_q;
		s_tready       = 1'b0;
		load           = 1'b0;
		ctl.compare    = 1'b0;
		ctl.shift_up   = 1'b0;
		ctl.shift_down = 1'b0;
		unique case (state_q)
			FSM_IDLE: begin
				s_tready    = 1'b1;
				ctl.compare = s_tvalid;
				if (s_tvalid) begin
					state_nxt = FSM_UPDATE;
				end
			end
			FSM_UPDATE: begin
				if (!m_tvalid_q || m_tready) begin
					load           = 1'b1;
					ctl.shift_up   = (cmd_q == CMD_INSERT) && not_full;
					ctl.shift_down = (cmd_q == CMD_REMOVE) && found;
					state_nxt      = FSM_IDLE;
				end
			end
			default: begin
				state_nxt = FSM_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= s_tdata[CMD_W-1:0];
			key_q <= in_key;
		end
	end

	// Row of cells; each hands its key to the neighbors on a shift.
	for (genvar i = 0; i < SIZE; i++) begin : g_cell
		logic [KEY_WIDTH-1:0] left_key;
		logic [KEY_WIDTH-1:0] right_key;
		logic                 lt_left;

		assign cell_valid[i] = (CW'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_key = cell_key[i];
			assign lt_left  = 1'b1;
		end else begin : g_inner
			assign left_key = cell_key[i-1];
			assign lt_left  = cell_lt[i-1];
		end

		if (i == SIZE - 1) begin : g_last
			assign right_key = cell_key[i];
		end else begin : g_body
			assign right_key = cell_key[i+1];
		end

		skn_cell #(
			.KEY_WIDTH(KEY_WIDTH)
		) u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.valid    (cell_valid[i]),
			.cmp_key  (in_key),
			.ins_key  (key_q),
			.left_key (left_key),
			.right_key(right_key),
			.lt_left  (lt_left),
			.key      (cell_key[i]),
			.lt       (cell_lt[i]),
			.at_pos   (cell_at_pos[i]),
			.hit      (cell_hit[i])
		);
	end

	// The lower-than flags form a run of ones; the first cell past the end of the run is the position.
	always_comb begin
		pos_enc = '0;
		for (int i = 0; i < SIZE; i++) begin
			if (cell_at_pos[i]) begin
				pos_enc = pos_enc | CW'(i);
			end
		end
	end

	assign pos   = cell_lt[SIZE-1] ? CW'(SIZE) : pos_enc;
	assign found = |cell_hit;

	always_comb begin
		status    = ST_DONE;
		pos_out   = pos;
		found_out = found;
		count_nxt = count_q;
		unique case (cmd_q)
			CMD_INSERT: begin
				if (!not_full) begin
					status = ST_FULL;
				end else begin
					count_nxt = count_q + CW'(1);
				end
			end
			CMD_REMOVE: begin
				if (count_q == '0) begin
					status    = ST_EMPTY;
					pos_out   = '0;
					found_out = 1'b0;
				end else if (!found) begin
					status = ST_NOT_FOUND;
				end else begin
					count_nxt = count_q - CW'(1);
				end
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	assign pos_pad   = {{POS_W{1'b0}}, pos_out};
	assign count_pad = {{COUNT_W{1'b0}}, count_nxt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (load) begin
				count_q    <= count_nxt;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata_q <= {3'd0, count_pad[COUNT_W-1:0], found_out, pos_pad[POS_W-1:0], status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`SKN_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(SIZE), "key count above SIZE")
	`SKN_ASSERT_IMP(a_single_pos, state_q == FSM_UPDATE, $onehot0(cell_at_pos), "several insertion points in the row")
	`SKN_ASSERT_IMP(a_rose_from_update, $rose(m_tvalid), $past(state_q == FSM_UPDATE), "result without an update cycle")
	`SKN_ASSERT_NXT(a_accept_to_update, accept, state_q == FSM_UPDATE, "accepted item did not reach the update cycle")
	`SKN_ASSERT_NXT(a_insert_count, ctl.shift_up, count_q == $past(count_q) + CW'(1), "insert did not grow the count")

endmodule
`default_nettype wire

### rtl/skn_cell.sv
// One storage cell of the sorted key row: holds a key and its compare flags.
`timescale 1ns / 1ps
`default_nettype none
module skn_cell #(
	parameter int KEY_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire skn_pkg::skn_ctl_t    ctl,
	input  wire logic                 valid,
	input  wire logic [KEY_WIDTH-1:0] cmp_key,
	input  wire logic [KEY_WIDTH-1:0] ins_key,
	input  wire logic [KEY_WIDTH-1:0] left_key,
	input  wire logic [KEY_WIDTH-1:0] right_key,
	input  wire logic                 lt_left,
	output logic      [KEY_WIDTH-1:0] key,
	output logic                      lt,
	output logic                      at_pos,
	output logic                      hit
);
	import skn_pkg::*;

	logic [KEY_WIDTH-1:0] key_q;
	logic                 lt_q;
	logic                 eq_q;
	logic                 valid_q;

	always_ff @(posedge clk) begin
		if (ctl.compare) begin
			lt_q    <= valid && (key_q < cmp_key);
			eq_q    <= (key_q == cmp_key);
			valid_q <= valid;
		end
		// Cells at or past the insertion point move up, the new key lands at the point; on a remove they take the key above.
		if (ctl.shift_up && !lt_q) begin
			key_q <= lt_left ? ins_key : left_key;
		end else if (ctl.shift_down && !lt_q) begin
			key_q <= right_key;
		end
	end

	assign key    = key_q;
	assign lt     = lt_q;
	assign at_pos = !lt_q && lt_left;
	assign hit    = at_pos && eq_q && valid_q;

endmodule
`default_nettype wire
